// ----- design/ecgrpd_pkg.sv -----
// ecgrpd_pkg: constants, register indexes and shared types for the R-peak detector.
// No dependencies; imported by every module of the block.
package ecgrpd_pkg;

  // Configuration port
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;

  localparam logic [CFG_INDEX_W-1:0] REG_SAMPLE_RATE    = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_BLIND_SAMPLES  = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_LOW_DETECT     = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_INIT_THRESHOLD = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_INIT_MEAN      = 3'd4;

  // Register reset values
  localparam logic [CFG_DATA_W-1:0] RST_SAMPLE_RATE   = 16'd500;
  localparam logic [CFG_DATA_W-1:0] RST_BLIND_SAMPLES = 16'd100;
  localparam logic [CFG_DATA_W-1:0] RST_LOW_DETECT    = 16'd50;
  localparam int                    INIT_THRESHOLD    = 1800;
  localparam int                    INIT_MEAN         = 1800;

  // Q0.16 blend coefficients, truncated toward zero
  localparam int COEF_W = 16;
  localparam logic [COEF_W-1:0] COEF_080 = 16'd52428;
  localparam logic [COEF_W-1:0] COEF_065 = 16'd42598;
  localparam logic [COEF_W-1:0] COEF_030 = 16'd19660;
  localparam logic [COEF_W-1:0] COEF_020 = 16'd13107;

  // Tick counter and deadline width (wrap-around compare)
  localparam int TICK_W = 32;

  // Phase codes
  localparam logic [1:0] PH_BLIND = 2'd0;
  localparam logic [1:0] PH_LOW   = 2'd1;
  localparam logic [1:0] PH_DECAY = 2'd2;

  localparam int BEAT_W = 16;

  typedef struct packed {
    logic [CFG_DATA_W-1:0] sample_rate;
    logic [CFG_DATA_W-1:0] blind_samples;
    logic [CFG_DATA_W-1:0] low_detect_samples;
  } cfg_t;

endpackage

// ----- design/ecgrpd_window.sv -----
// ecgrpd_window: five-sample delay line, warm-up count and block-mean accumulator.
// Depends on ecgrpd_pkg.
module ecgrpd_window #(
  parameter int WINDOW      = 256,
  parameter int SAMPLE_BITS = 12
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   step,
  input  logic [SAMPLE_BITS-1:0] sample_in,
  output logic                   judge,
  output logic [SAMPLE_BITS-1:0] x,
  output logic [SAMPLE_BITS-1:0] xm2,
  output logic [SAMPLE_BITS-1:0] xm1,
  output logic [SAMPLE_BITS-1:0] xp1,
  output logic [SAMPLE_BITS-1:0] xp2,
  output logic [SAMPLE_BITS-1:0] mean,
  output logic [SAMPLE_BITS-1:0] mean_next
);
  import ecgrpd_pkg::*;

  localparam int FILL_W = $clog2(WINDOW);
  localparam int SHIFT  = $clog2(WINDOW + 1) - 1;
  localparam int SUM_W  = SAMPLE_BITS + FILL_W;
  localparam logic [FILL_W-1:0] FILL_LAST = FILL_W'(WINDOW - 1);

  logic [SAMPLE_BITS-1:0] taps [4];
  logic [1:0]             warmup_count;
  logic [SUM_W-1:0]       window_sum;
  logic [SUM_W-1:0]       sum_add;
  logic [SUM_W-1:0]       sum_shifted;
  logic [FILL_W-1:0]      window_fill;
  logic                   fill_last;

  assign xp2   = sample_in;
  assign xp1   = taps[0];
  assign x     = taps[1];
  assign xm1   = taps[2];
  assign xm2   = taps[3];
  assign judge = step && (warmup_count == 2'd2);

  assign sum_add     = window_sum + SUM_W'(x);
  assign sum_shifted = sum_add >> SHIFT;
  assign fill_last   = (window_fill == FILL_LAST);

  always_comb begin
    mean_next = mean;
    if (judge && fill_last) begin
      if (|sum_shifted[SUM_W-1:SAMPLE_BITS]) begin
        mean_next = '1;
      end else begin
        mean_next = sum_shifted[SAMPLE_BITS-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      taps         <= '{default: '0};
      warmup_count <= '0;
      window_sum   <= '0;
      window_fill  <= '0;
      mean         <= SAMPLE_BITS'(INIT_MEAN);
    end else if (step) begin
      taps[0] <= sample_in;
      taps[1] <= taps[0];
      taps[2] <= taps[1];
      taps[3] <= taps[2];
      if (!judge) begin
        warmup_count <= warmup_count + 2'd1;
      end else begin
        mean <= mean_next;
        if (fill_last) begin
          window_sum  <= '0;
          window_fill <= '0;
        end else begin
          window_sum  <= sum_add;
          window_fill <= window_fill + FILL_W'(1);
        end
      end
    end
  end

endmodule

// ----- design/ecgrpd_thresh.sv -----
// ecgrpd_thresh: peak decision, tick deadline phase machine and threshold blend.
// Depends on ecgrpd_pkg.
module ecgrpd_thresh #(
  parameter int SAMPLE_BITS = 12
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          judge,
  input  logic [SAMPLE_BITS-1:0]        x,
  input  logic [SAMPLE_BITS-1:0]        xm2,
  input  logic [SAMPLE_BITS-1:0]        xm1,
  input  logic [SAMPLE_BITS-1:0]        xp1,
  input  logic [SAMPLE_BITS-1:0]        xp2,
  input  logic [SAMPLE_BITS-1:0]        mean,
  input  ecgrpd_pkg::cfg_t              cfg,
  output logic                          is_peak,
  output logic signed [SAMPLE_BITS+1:0] thr_next,
  output logic [ecgrpd_pkg::BEAT_W-1:0] beats_next,
  output logic [1:0]                    phase_next
);
  import ecgrpd_pkg::*;

  localparam int TH_W = SAMPLE_BITS + 2;
  localparam int PR_W = SAMPLE_BITS + COEF_W + 2;

  logic signed [TH_W-1:0]   thr;
  logic [BEAT_W-1:0]        beats;
  logic [1:0]               phase;
  logic                     in_blind;
  logic                     blind_next;
  logic [SAMPLE_BITS-1:0]   last_peak;
  logic [TICK_W-1:0]        tick;
  logic [TICK_W-1:0]        tick_inc;
  logic [TICK_W-1:0]        since_dl;
  logic [TICK_W-1:0]        deadline;
  logic [TICK_W-1:0]        dl_next;
  logic                     reached;
  logic                     thr_upd;
  logic [COEF_W-1:0]        coef;
  logic [SAMPLE_BITS-1:0]   peak_val;
  logic signed [SAMPLE_BITS:0] diff;
  logic signed [PR_W-1:0]   prod;
  logic signed [PR_W-1:0]   total;
  logic signed [TH_W-1:0]   thr_blend;

  assign tick_inc = tick + TICK_W'(1);
  assign since_dl = tick_inc - deadline;
  assign reached  = ~since_dl[TICK_W-1];

  assign is_peak = judge && ($signed({2'b00, x}) >= thr) && (x > xm1) && (x > xm2) &&
                   (x > xp1) && (x > xp2) && !in_blind;

  // Blend: mean + coef * (peak - mean), floored; result lies between mean and peak
  assign peak_val  = is_peak ? x : last_peak;
  assign diff      = $signed({1'b0, peak_val}) - $signed({1'b0, mean});
  assign prod      = diff * $signed({1'b0, coef});
  assign total     = $signed({2'b00, mean, COEF_W'(0)}) + prod;
  assign thr_blend = $signed({2'b00, total[SAMPLE_BITS+COEF_W-1:COEF_W]});

  always_comb begin
    dl_next    = deadline;
    phase_next = phase;
    blind_next = in_blind;
    beats_next = beats;
    thr_upd    = 1'b0;
    coef       = COEF_080;
    if (is_peak) begin
      beats_next = beats + BEAT_W'(1);
      thr_upd    = 1'b1;
      // zero blind interval: deadline already reached, drop straight to the low phase
      if (cfg.blind_samples == '0) begin
        coef       = COEF_065;
        phase_next = PH_LOW;
        blind_next = 1'b0;
        dl_next    = tick_inc + TICK_W'(cfg.low_detect_samples);
      end else begin
        phase_next = PH_BLIND;
        blind_next = 1'b1;
        dl_next    = tick_inc + TICK_W'(cfg.blind_samples);
      end
    end else if (judge && reached) begin
      case (phase)
        PH_BLIND: begin
          if (in_blind) begin
            coef       = COEF_065;
            thr_upd    = 1'b1;
            phase_next = PH_LOW;
            blind_next = 1'b0;
            dl_next    = deadline + TICK_W'(cfg.low_detect_samples);
          end
        end
        PH_LOW: begin
          if (!in_blind) begin
            coef       = COEF_030;
            thr_upd    = 1'b1;
            phase_next = PH_DECAY;
            dl_next    = deadline + TICK_W'(cfg.sample_rate);
          end
        end
        default: begin
          if (!in_blind) begin
            coef    = COEF_020;
            thr_upd = 1'b1;
            dl_next = deadline + TICK_W'(cfg.sample_rate[CFG_DATA_W-1:1]);
          end
        end
      endcase
    end
  end

  assign thr_next = thr_upd ? thr_blend : thr;

  always_ff @(posedge clk) begin
    if (rst) begin
      thr       <= $signed(TH_W'(INIT_THRESHOLD));
      beats     <= '0;
      phase     <= PH_BLIND;
      in_blind  <= 1'b0;
      last_peak <= '0;
      tick      <= '0;
      deadline  <= '0;
    end else if (judge) begin
      thr      <= thr_next;
      beats    <= beats_next;
      phase    <= phase_next;
      in_blind <= blind_next;
      tick     <= tick_inc;
      deadline <= dl_next;
      if (is_peak) begin
        last_peak <= x;
      end
    end
  end

endmodule

// ----- design/ecg_r_peak_decaying_threshold.sv -----
// ecg_r_peak_decaying_threshold: top level of the ECG R-peak detector.
// Depends on ecgrpd_pkg, ecgrpd_window and ecgrpd_thresh.
//
// Usage
//   Input channel (in_valid/in_ready, sample): one converter sample per transfer.
//   Output channel (out_valid/out_ready): exactly one result per input sample,
//   judging the sample two inputs back. The first two results after reset carry
//   sample_valid = 0 and show the untouched detector state.
//   Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data): always ready;
//   write only while no sample is in flight. Indexes 3 and 4 (initial threshold
//   and mean) are reloaded from their defaults by reset, so writes to them have
//   no lasting effect; indexes above 4 are ignored.
// Timing
//   Two register stages: input register, then the result register. out_valid
//   rises once the sample has passed the input register into the result
//   register. Throughput is one sample per cycle unless out_ready stalls the
//   result; all detector state updates together on each step, the critical path
//   being the peak compare, coefficient select, the 13x17 blend multiply and its add.
// Stall
//   A stalled result holds; the input register still takes one more sample, and
//   in_ready drops only when both stages are full and out_ready is low.
// Reset
//   Synchronous, active high: config to defaults, threshold and mean to 1800,
//   counters, phase and the delay line cleared, both stages emptied.
module ecg_r_peak_decaying_threshold #(
  parameter int WINDOW      = 256,
  parameter int SAMPLE_BITS = 12
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [SAMPLE_BITS-1:0]              sample,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                sample_valid,
  output logic                                is_peak,
  output logic signed [SAMPLE_BITS+1:0]       threshold,
  output logic [ecgrpd_pkg::BEAT_W-1:0]       beat_count,
  output logic [1:0]                          phase,
  output logic [SAMPLE_BITS-1:0]              window_mean,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [ecgrpd_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [ecgrpd_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import ecgrpd_pkg::*;

  localparam int TH_W = SAMPLE_BITS + 2;

  cfg_t cfg;

  // input stage
  logic                   s1_valid;
  logic [SAMPLE_BITS-1:0] s1_sample;
  logic                   advance;
  logic                   step;

  // window/detector wiring
  logic                   judge;
  logic [SAMPLE_BITS-1:0] x, xm2, xm1, xp1, xp2;
  logic [SAMPLE_BITS-1:0] mean, mean_next;
  logic                   peak_now;
  logic signed [TH_W-1:0] thr_next;
  logic [BEAT_W-1:0]      beats_next;
  logic [1:0]             phase_next;

  // result register
  logic                   res_valid;
  logic                   res_sample_valid;
  logic                   res_is_peak;
  logic signed [TH_W-1:0] res_threshold;
  logic [BEAT_W-1:0]      res_beats;
  logic [1:0]             res_phase;
  logic [SAMPLE_BITS-1:0] res_mean;

  assign advance  = !res_valid || out_ready;
  assign step     = s1_valid && advance;
  assign in_ready = !s1_valid || advance;

  // Config registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sample_rate        <= RST_SAMPLE_RATE;
      cfg.blind_samples      <= RST_BLIND_SAMPLES;
      cfg.low_detect_samples <= RST_LOW_DETECT;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_SAMPLE_RATE:    cfg.sample_rate        <= cfg_data;
        REG_BLIND_SAMPLES:  cfg.blind_samples      <= cfg_data;
        REG_LOW_DETECT:     cfg.low_detect_samples <= cfg_data;
        REG_INIT_THRESHOLD: begin
          // reset value only
        end
        REG_INIT_MEAN: begin
          // reset value only
        end
        default: begin
        end
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_sample <= sample;
    end
  end

  ecgrpd_window #(
    .WINDOW      (WINDOW),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_window (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .sample_in (s1_sample),
    .judge     (judge),
    .x         (x),
    .xm2       (xm2),
    .xm1       (xm1),
    .xp1       (xp1),
    .xp2       (xp2),
    .mean      (mean),
    .mean_next (mean_next)
  );

  ecgrpd_thresh #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_thresh (
    .clk        (clk),
    .rst        (rst),
    .judge      (judge),
    .x          (x),
    .xm2        (xm2),
    .xm1        (xm1),
    .xp1        (xp1),
    .xp2        (xp2),
    .mean       (mean),
    .cfg        (cfg),
    .is_peak    (peak_now),
    .thr_next   (thr_next),
    .beats_next (beats_next),
    .phase_next (phase_next)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res_sample_valid <= judge;
      res_is_peak      <= peak_now;
      res_threshold    <= thr_next;
      res_beats        <= beats_next;
      res_phase        <= phase_next;
      res_mean         <= mean_next;
    end
  end

  assign out_valid    = res_valid;
  assign sample_valid = res_sample_valid;
  assign is_peak      = res_is_peak;
  assign threshold    = res_threshold;
  assign beat_count   = res_beats;
  assign phase        = res_phase;
  assign window_mean  = res_mean;

  // Checks
  a_peak_needs_valid: assert property (@(posedge clk) disable iff (rst)
    out_valid && is_peak |-> sample_valid)
    else $error("peak flagged on a warm-up result");

  a_peak_phase: assert property (@(posedge clk) disable iff (rst)
    out_valid && is_peak |-> (phase == PH_BLIND || phase == PH_LOW))
    else $error("peak result not in blind or low phase");

  a_thr_nonneg: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !threshold[TH_W-1])
    else $error("threshold went negative");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty result stage");

endmodule

// ----- bench/ecg_r_peak_decaying_threshold_tb.sv -----
// Self-checking bench for ecg_r_peak_decaying_threshold: directed samples, then beat-shaped
// random traffic, checked against a cycle-free model of the detector held in the bench.
// Depends on ecgrpd_pkg and the design files of the block.
`timescale 1ns / 1ps

module ecg_r_peak_decaying_threshold_tb;
  import ecgrpd_pkg::*;

  localparam int CLK_PERIOD  = 20;
  localparam int WIN         = 256;
  localparam int SBITS       = 12;
  localparam int SAMPLE_MAX  = (1 << SBITS) - 1;
  localparam int WIN_SHIFT   = $clog2(WIN);   // window is a power of two here
  localparam int PHASE_ITEMS = 120;
  localparam int N_PLANS     = 7;
  localparam int N_INTRO     = 23;
  localparam int DRAIN_LIMIT = 2000;
  localparam int MAX_REPORTS = 10;

  // One result as seen on the output channel.
  typedef struct packed {
    logic                   vld;
    logic                   pk;
    logic signed [SBITS+1:0] thr;
    logic [BEAT_W-1:0]      beats;
    logic [1:0]             ph;
    logic [SBITS-1:0]       mean;
  } ecg_result_t;

  // Result of either warm-up sample: nothing judged yet, reset state on show.
  localparam ecg_result_t WARMUP_RESULT = {1'b0, 1'b0, 14'sd1800, 16'd0, PH_BLIND, 12'd1800};

  // Directed stimulus row: the sample and whether its result is the warm-up one.
  typedef struct packed {
    logic [SBITS-1:0] value;
    logic             warm_row;
  } intro_row_t;

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   in_valid;
  logic                   in_ready;
  logic [SBITS-1:0]       sample;
  logic                   out_valid;
  logic                   out_ready;
  logic                   sample_valid;
  logic                   is_peak;
  logic signed [SBITS+1:0] threshold;
  logic [BEAT_W-1:0]      beat_count;
  logic [1:0]             phase;
  logic [SBITS-1:0]       window_mean;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  always #(CLK_PERIOD / 2) clk = ~clk;

  ecg_r_peak_decaying_threshold #(
    .WINDOW      (WIN),
    .SAMPLE_BITS (SBITS)
  ) u_top (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .sample       (sample),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .sample_valid (sample_valid),
    .is_peak      (is_peak),
    .threshold    (threshold),
    .beat_count   (beat_count),
    .phase        (phase),
    .window_mean  (window_mean),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  // ---------------------------------------------------------------------------
  // Detector model: register copies and detector state, updated per transfer.
  // ---------------------------------------------------------------------------
  logic [CFG_DATA_W-1:0] rate, blind_len, low_len;
  logic [SBITS-1:0]      init_thr, init_mean;   // only read at reset

  logic [SBITS-1:0]  hist [4];    // [0] newest .. [3] oldest
  int                warm;
  logic [TICK_W-1:0] ticks, due;
  logic [1:0]        ph_now;
  logic              blind;
  logic [SBITS-1:0]  peak_val;
  int                thr_now;
  logic [SBITS-1:0]  mean_now;
  int                win_sum;
  int                win_fill;
  logic [BEAT_W-1:0] beats;

  ecg_result_t pending_q [$];     // results owed by the block, oldest first
  int          faults;
  int          sent_count;
  logic        steady;            // no idling on either side while set

  function automatic void reset_model();
    rate      = RST_SAMPLE_RATE;
    blind_len = RST_BLIND_SAMPLES;
    low_len   = RST_LOW_DETECT;
    init_thr  = SBITS'(INIT_THRESHOLD);
    init_mean = SBITS'(INIT_MEAN);
    foreach (hist[i]) hist[i] = '0;
    warm     = 0;
    ticks    = '0;
    due      = '0;
    ph_now   = PH_BLIND;
    blind    = 1'b0;
    peak_val = '0;
    thr_now  = int'(init_thr);
    mean_now = init_mean;
    win_sum  = 0;
    win_fill = 0;
    beats    = '0;
  endfunction

  function automatic void apply_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    case (idx)
      REG_SAMPLE_RATE:    rate      = val;
      REG_BLIND_SAMPLES:  blind_len = val;
      REG_LOW_DETECT:     low_len   = val;
      REG_INIT_THRESHOLD: init_thr  = val[SBITS-1:0];
      REG_INIT_MEAN:      init_mean = val[SBITS-1:0];
      default: ;          // unmapped index: dropped
    endcase
  endfunction

  // Threshold between mean and last peak: floor((mean*2^16 + (peak-mean)*coef) / 2^16).
  function automatic int blend_thr(logic [COEF_W-1:0] coef);
    longint base, span, acc;
    base = longint'(mean_now);
    span = longint'(peak_val) - base;
    acc  = base * 65536 + span * longint'(coef);
    if (acc < 0) acc = 0;
    return int'(acc >>> 16);
  endfunction

  // Wrap-safe: deadline reached when tick - deadline lands in the lower half.
  function automatic logic due_reached();
    logic [TICK_W-1:0] lag;
    lag = ticks - due;
    return !lag[TICK_W-1];
  endfunction

  // Push one sample through the detector model and return the result it causes.
  function automatic ecg_result_t judge_sample(logic [SBITS-1:0] s);
    logic [SBITS-1:0] nxt1, mid, prv1, prv2;
    ecg_result_t      r;
    int               m;
    nxt1 = hist[0];
    mid  = hist[1];
    prv1 = hist[2];
    prv2 = hist[3];
    hist[3] = hist[2];
    hist[2] = hist[1];
    hist[1] = hist[0];
    hist[0] = s;
    r.vld = 1'b0;
    r.pk  = 1'b0;
    if (warm < 2) begin
      warm++;
    end else begin
      r.vld = 1'b1;
      ticks++;
      win_sum += int'(mid);
      if (int'(mid) >= thr_now && mid > prv1 && mid > prv2 && mid > nxt1 && mid > s &&
          !blind) begin
        r.pk     = 1'b1;
        beats++;
        peak_val = mid;
        thr_now  = blend_thr(COEF_080);
        due      = ticks + TICK_W'(blind_len);
        blind    = 1'b1;
        ph_now   = PH_BLIND;
      end
      case (ph_now)
        PH_BLIND: if (due_reached() && blind) begin
          thr_now = blend_thr(COEF_065);
          due     = due + TICK_W'(low_len);
          blind   = 1'b0;
          ph_now  = PH_LOW;
        end
        PH_LOW: if (due_reached() && !blind) begin
          due     = due + TICK_W'(rate);
          thr_now = blend_thr(COEF_030);
          ph_now  = PH_DECAY;
        end
        default: if (due_reached() && !blind) begin
          due     = due + TICK_W'(rate >> 1);
          thr_now = blend_thr(COEF_020);
        end
      endcase
      win_fill++;
      if (win_fill >= WIN) begin
        m        = win_sum >> WIN_SHIFT;
        mean_now = (m > SAMPLE_MAX) ? SAMPLE_MAX[SBITS-1:0] : m[SBITS-1:0];
        win_sum  = 0;
        win_fill = 0;
      end
    end
    r.thr   = thr_now[SBITS+1:0];
    r.beats = beats;
    r.ph    = ph_now;
    r.mean  = mean_now;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Channel drivers. Everything driven at the falling edge, sampled at the rising.
  // ---------------------------------------------------------------------------

  // Mostly back to back, some short pauses, the odd long one.
  function automatic int idle_len();
    int r;
    if (steady) return 0;
    r = int'($urandom_range(0, 99));
    if (r < 55) return 0;
    if (r < 85) return int'($urandom_range(1, 3));
    if (r < 96) return int'($urandom_range(4, 12));
    return int'($urandom_range(20, 60));
  endfunction

  // One sample transfer; valid stays up between back-to-back samples.
  task automatic send_sample(logic [SBITS-1:0] value, logic warm_row);
    int          gap;
    ecg_result_t want;
    gap = idle_len();
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    sample   = value;
    do @(posedge clk); while (!in_ready);
    want = judge_sample(value);
    pending_q.push_back(warm_row ? WARMUP_RESULT : want);
    sent_count++;
  endtask

  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    do @(posedge clk); while (!cfg_ready);
    apply_reg(idx, val);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Full register pass. The initial threshold and mean only matter at reset,
  // so random data there must leave the run untouched; same for unmapped indexes.
  task automatic program_regs(logic [CFG_DATA_W-1:0] r, logic [CFG_DATA_W-1:0] b,
                              logic [CFG_DATA_W-1:0] l);
    write_reg(REG_SAMPLE_RATE, r);
    write_reg(REG_BLIND_SAMPLES, b);
    write_reg(REG_LOW_DETECT, l);
    write_reg(REG_INIT_THRESHOLD, CFG_DATA_W'($urandom));
    write_reg(REG_INIT_MEAN, CFG_DATA_W'($urandom));
    for (int i = int'(REG_INIT_MEAN) + 1; i < (1 << CFG_INDEX_W); i++)
      write_reg(CFG_INDEX_W'(i), CFG_DATA_W'($urandom));
  endtask

  // Stop sending and wait for every owed result, plus a little pipeline slack.
  task automatic settle();
    int guard;
    @(negedge clk);
    in_valid = 1'b0;
    guard = 0;
    while (pending_q.size() != 0 && guard < DRAIN_LIMIT) begin
      @(posedge clk);
      guard++;
    end
    repeat (4) @(posedge clk);
  endtask

  // Beat-shaped traffic: baseline, a rise, a single sharp top, a fall. Some tops are
  // flat (two equal samples, no strict maximum) and some stretches are plain noise.
  task automatic play_rhythm(int n_items);
    int stop_at, r, base, pk;
    stop_at = sent_count + n_items;
    while (sent_count < stop_at) begin
      r = int'($urandom_range(0, 99));
      if (r < 12) begin
        repeat ($urandom_range(1, 6)) send_sample(SBITS'($urandom_range(0, SAMPLE_MAX)), 1'b0);
      end else begin
        base = int'($urandom_range(0, 1200));
        repeat ($urandom_range(1, 12)) send_sample(SBITS'(base + $urandom_range(0, 150)), 1'b0);
        pk = int'($urandom_range(base + 300, SAMPLE_MAX));
        send_sample(SBITS'(pk - $urandom_range(1, pk - base)), 1'b0);
        send_sample(SBITS'(pk), 1'b0);
        if (r < 22) send_sample(SBITS'(pk), 1'b0);
        send_sample(SBITS'(pk - $urandom_range(1, pk - base)), 1'b0);
      end
    end
  endtask

  // Receiver: ready for a cycle, then maybe a stall of random length.
  initial begin
    int hold;
    out_ready = 1'b0;
    hold = 0;
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        out_ready = 1'b0;
        hold--;
      end else begin
        out_ready = 1'b1;
        hold = idle_len();
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------------
  task automatic report_fault(string what, ecg_result_t want, ecg_result_t got);
    faults++;
    if (faults <= MAX_REPORTS) begin
      $write("%0t %s: want vld=%0b peak=%0b thr=%0d beats=%0d phase=%0d mean=%0d",
             $time, what, want.vld, want.pk, $signed(want.thr), want.beats, want.ph,
             want.mean);
      $display(" | got vld=%0b peak=%0b thr=%0d beats=%0d phase=%0d mean=%0d",
               got.vld, got.pk, $signed(got.thr), got.beats, got.ph, got.mean);
    end
  endtask

  always @(posedge clk) begin
    ecg_result_t got, want;
    if (!rst && out_valid && out_ready) begin
      got = {sample_valid, is_peak, threshold, beat_count, phase, window_mean};
      if (pending_q.size() == 0) begin
        report_fault("result with nothing owed", '0, got);
      end else begin
        want = pending_q.pop_front();
        if (got !== want) report_fault("result mismatch", want, got);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus plan
  // ---------------------------------------------------------------------------

  // Directed samples, run with rate 4, blind 4, low 2. A sample is judged two
  // transfers after it arrives; tick n judges sample n-1 and comes with the
  // transfer of sample n+1.
  intro_row_t intro_rows [N_INTRO] = '{
    '{12'd4095, 1'b1},  // warm-up; full-scale top with zero pre-reset neighbours
    '{12'd0,    1'b1},  // warm-up; all-zero sample
    '{12'd0,    1'b0},  // first judged: 4095 is a peak, threshold to 0.80 blend
    '{12'd4095, 1'b0},  // sharp top inside the blind interval: must be ignored
    '{12'd0,    1'b0},
    '{12'd0,    1'b0},
    '{12'd0,    1'b0},  // blind ends with this transfer, 0.65 step
    '{12'd3000, 1'b0},  // flat top above threshold: neither sample is a peak
    '{12'd3000, 1'b0},  // 0.30 step with this transfer
    '{12'd100,  1'b0},
    '{12'd100,  1'b0},
    '{12'd2258, 1'b0},  // top exactly on the decayed threshold: a peak
    '{12'd100,  1'b0},  // first 0.20 step with this transfer, before the top is judged
    '{12'd100,  1'b0},
    '{12'd100,  1'b0},
    '{12'd100,  1'b0},
    '{12'd100,  1'b0},
    '{12'd100,  1'b0},  // blind ends again, 0.65 step
    '{12'd1936, 1'b0},  // one below the 0.30 threshold: not a peak
    '{12'd100,  1'b0},  // 0.30 step, just before the sample above is judged
    '{12'd100,  1'b0},
    '{12'd100,  1'b0},
    '{12'd100,  1'b0}   // next 0.20 step falls on the first random transfer
  };

  // Register settings per random phase. Rate 0 and 1 make the 0.20 step fire on
  // every sample; the all-maximum set comes last since it parks the detector.
  logic [CFG_DATA_W-1:0] plan_rate  [N_PLANS] = '{16'd20, 16'd2, 16'd0, 16'd1, 16'd50,
                                                  16'd9, 16'd65535};
  logic [CFG_DATA_W-1:0] plan_blind [N_PLANS] = '{16'd10, 16'd0, 16'd3, 16'd1, 16'd30,
                                                  16'd6, 16'd65535};
  logic [CFG_DATA_W-1:0] plan_low   [N_PLANS] = '{16'd5, 16'd0, 16'd1, 16'd2, 16'd0,
                                                  16'd3, 16'd65535};

  initial begin
    rst        = 1'b1;
    in_valid   = 1'b0;
    sample     = '0;
    cfg_valid  = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    faults     = 0;
    sent_count = 0;
    steady     = 1'b0;
    reset_model();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    program_regs(16'd4, 16'd4, 16'd2);
    foreach (intro_rows[i]) send_sample(intro_rows[i].value, intro_rows[i].warm_row);
    settle();

    for (int p = 0; p < N_PLANS; p++) begin
      steady = (p % 3 == 1);
      program_regs(plan_rate[p], plan_blind[p], plan_low[p]);
      play_rhythm(PHASE_ITEMS);
      settle();
    end

    while (pending_q.size() != 0) report_fault("no result for sample", pending_q.pop_front(), '0);

    if (faults == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Watchdog: the slowest legal run is a few ms; this is several times that.
  initial begin
    #(64'd20_000_000);
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

// ----- ecg_r_peak_decaying_threshold.f -----
design/ecgrpd_pkg.sv
design/ecgrpd_window.sv
design/ecgrpd_thresh.sv
design/ecg_r_peak_decaying_threshold.sv
bench/ecg_r_peak_decaying_threshold_tb.sv
